FILE: rtl/alc_pkg.sv
// ----------------------------------------------------------------------------
// alc_pkg
// Shared types and constants for the alarm clock block.
// ----------------------------------------------------------------------------
package alc_pkg;

  typedef struct packed {
    logic [4:0] h;
    logic [5:0] m;
    logic [5:0] s;
  } hms_t;

  typedef enum logic [1:0] {
    MODE_SHOW      = 2'd0,
    MODE_SET_TIME  = 2'd1,
    MODE_SET_ALARM = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    FLD_HOURS   = 2'd0,
    FLD_MINUTES = 2'd1,
    FLD_SECONDS = 2'd2
  } field_t;

  // register file
  localparam int          ADDR_W     = 3;
  localparam logic        REG_TPS    = 1'b0;
  localparam logic        REG_TPB    = 1'b1;
  localparam logic [15:0] TPS_RESET  = 16'd1000;
  localparam logic [15:0] TPB_RESET  = 16'd500;

  // key commands (edge-detected press values)
  localparam logic [4:0] KEY_SET_TIME  = 5'd4;
  localparam logic [4:0] KEY_SET_ALARM = 5'd5;
  localparam logic [4:0] KEY_CANCEL    = 5'd6;
  localparam logic [4:0] KEY_COMMIT    = 5'd7;
  localparam logic [4:0] KEY_NEXT_FLD  = 5'd8;
  localparam logic [4:0] KEY_UP        = 5'd12;
  localparam logic [4:0] KEY_STEP_DN   = 5'd13;
  localparam logic [4:0] KEY_ARM       = 5'd16;

  localparam logic [4:0] HOUR_MAX = 5'd23;
  localparam logic [5:0] MS_MAX   = 6'd59;
  localparam logic [4:0] HOUR_PM  = 5'd12;

  localparam hms_t TIME_RESET  = '{h: 5'd23, m: 6'd59, s: 6'd55};
  localparam hms_t ALARM_RESET = '{h: 5'd0, m: 6'd0, s: 6'd0};

  localparam logic [7:0] LED_PM = 8'hF0;
  localparam logic [7:0] LED_AM = 8'h0F;

  typedef struct packed {
    logic [15:0] ticks_per_second;
    logic [15:0] ticks_per_blink;
  } cfg_t;

  typedef struct packed {
    mode_t      mode;
    hms_t       shown;
    field_t     field_sel;
    logic       blink;
    logic       armed;
    logic       ringing;
    logic [7:0] leds;
  } res_t;

endpackage

FILE: rtl/alc_cfg.sv
// ----------------------------------------------------------------------------
// alc_cfg
// APB register file: prescaler limits for seconds and blink phase.
// ----------------------------------------------------------------------------
module alc_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [alc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output alc_pkg::cfg_t             cfg
);
  import alc_pkg::*;

  logic [15:0] tps_r;
  logic [15:0] tpb_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // only the word index bit is decoded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
      tpb_r <= TPB_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_TPS) tps_r <= pwdata[15:0];
      if (paddr[2] == REG_TPB) tpb_r <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TPS) prdata[15:0] = tps_r;
    else                     prdata[15:0] = tpb_r;
  end

  assign cfg.ticks_per_second = tps_r;
  assign cfg.ticks_per_blink  = tpb_r;

endmodule

FILE: rtl/alc_core.sv
// ----------------------------------------------------------------------------
// alc_core
// Clock state and single-pass update for one tick or key word.
// ----------------------------------------------------------------------------
module alc_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic          op,
  input  logic [4:0]    key_code,
  input  alc_pkg::cfg_t cfg,
  output alc_pkg::res_t res
);
  import alc_pkg::*;

  logic [15:0] tick_cnt_r, tick_cnt_nxt;
  logic [15:0] blink_cnt_r, blink_cnt_nxt;
  logic        blink_r, blink_nxt;
  hms_t        time_r, time_nxt;
  hms_t        alarm_r, alarm_nxt;
  hms_t        edit_r, edit_nxt;
  mode_t       mode_r, mode_nxt;
  field_t      field_r, field_nxt;
  logic        armed_r, armed_nxt;
  logic        ring_r, ring_nxt;
  logic [4:0]  prev_key_r, prev_key_nxt;

  logic [4:0]  press;
  logic [5:0]  fval, ftop, fnew;
  logic        set_mode;

  always_comb begin
    tick_cnt_nxt  = tick_cnt_r;
    blink_cnt_nxt = blink_cnt_r;
    blink_nxt     = blink_r;
    time_nxt      = time_r;
    alarm_nxt     = alarm_r;
    edit_nxt      = edit_r;
    mode_nxt      = mode_r;
    field_nxt     = field_r;
    armed_nxt     = armed_r;
    ring_nxt      = ring_r;
    prev_key_nxt  = prev_key_r;
    press         = key_code & (key_code ^ prev_key_r);
    set_mode      = (mode_r == MODE_SET_TIME) || (mode_r == MODE_SET_ALARM);

    // selected field of the working copy, with its wrap limit
    case (field_r)
      FLD_HOURS:   fval = {1'b0, edit_r.h};
      FLD_MINUTES: fval = edit_r.m;
      default:     fval = edit_r.s;
    endcase
    ftop = (field_r == FLD_HOURS) ? {1'b0, HOUR_MAX} : MS_MAX;
    if (press == KEY_UP)
      fnew = (fval >= ftop) ? 6'd0 : fval + 6'd1;
    else
      fnew = (fval == 6'd0 || fval > ftop) ? ftop : fval - 6'd1;

    if (!op) begin
      if ({1'b0, tick_cnt_r} + 17'd1 >= {1'b0, cfg.ticks_per_second}) begin
        tick_cnt_nxt = '0;
        if (time_r.s >= MS_MAX) begin
          time_nxt.s = '0;
          if (time_r.m >= MS_MAX) begin
            time_nxt.m = '0;
            time_nxt.h = (time_r.h >= HOUR_MAX) ? 5'd0 : time_r.h + 5'd1;
          end else begin
            time_nxt.m = time_r.m + 6'd1;
          end
        end else begin
          time_nxt.s = time_r.s + 6'd1;
        end
      end else begin
        tick_cnt_nxt = tick_cnt_r + 16'd1;
      end
      if ({1'b0, blink_cnt_r} + 17'd1 >= {1'b0, cfg.ticks_per_blink}) begin
        blink_cnt_nxt = '0;
        blink_nxt     = ~blink_r;
      end else begin
        blink_cnt_nxt = blink_cnt_r + 16'd1;
      end
    end else begin
      prev_key_nxt = key_code;
      if (press != 5'd0) ring_nxt = 1'b0;
      case (press)
        KEY_SET_TIME: begin
          edit_nxt  = time_r;
          mode_nxt  = MODE_SET_TIME;
          field_nxt = FLD_HOURS;
        end
        KEY_SET_ALARM: begin
          edit_nxt  = alarm_r;
          mode_nxt  = MODE_SET_ALARM;
          field_nxt = FLD_HOURS;
        end
        KEY_CANCEL: mode_nxt = MODE_SHOW;
        KEY_COMMIT: begin
          if (mode_r == MODE_SET_TIME) begin
            time_nxt = edit_r;
            mode_nxt = MODE_SHOW;
          end else if (mode_r == MODE_SET_ALARM) begin
            alarm_nxt = edit_r;
            mode_nxt  = MODE_SHOW;
          end
        end
        KEY_NEXT_FLD: begin
          if (mode_r != MODE_SHOW) begin
            case (field_r)
              FLD_HOURS:   field_nxt = FLD_MINUTES;
              FLD_MINUTES: field_nxt = FLD_SECONDS;
              default:     field_nxt = FLD_HOURS;
            endcase
          end
        end
        KEY_UP, KEY_STEP_DN: begin
          if (set_mode) begin
            case (field_r)
              FLD_HOURS:   edit_nxt.h = fnew[4:0];
              FLD_MINUTES: edit_nxt.m = fnew;
              default:     edit_nxt.s = fnew;
            endcase
          end
        end
        KEY_ARM: armed_nxt = ~armed_r;
        default: ;
      endcase
    end

    if (armed_nxt && time_nxt == alarm_nxt) ring_nxt = 1'b1;
  end

  // result view of the updated state
  always_comb begin
    res.mode      = mode_nxt;
    res.shown     = (mode_nxt == MODE_SHOW) ? time_nxt : edit_nxt;
    res.field_sel = field_nxt;
    res.blink     = blink_nxt;
    res.armed     = armed_nxt;
    res.ringing   = ring_nxt;
    res.leds      = '0;
    if (armed_nxt && ring_nxt && blink_nxt)
      res.leds = (time_nxt.h >= HOUR_PM) ? LED_PM : LED_AM;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_cnt_r  <= '0;
      blink_cnt_r <= '0;
      blink_r     <= 1'b0;
      time_r      <= TIME_RESET;
      alarm_r     <= ALARM_RESET;
      mode_r      <= MODE_SHOW;
      field_r     <= FLD_HOURS;
      armed_r     <= 1'b0;
      ring_r      <= 1'b0;
      prev_key_r  <= '0;
    end else if (step) begin
      tick_cnt_r  <= tick_cnt_nxt;
      blink_cnt_r <= blink_cnt_nxt;
      blink_r     <= blink_nxt;
      time_r      <= time_nxt;
      alarm_r     <= alarm_nxt;
      mode_r      <= mode_nxt;
      field_r     <= field_nxt;
      armed_r     <= armed_nxt;
      ring_r      <= ring_nxt;
      prev_key_r  <= prev_key_nxt;
    end
  end

  // working copy is only read after a set key has loaded it
  always_ff @(posedge clk) begin
    if (step) edit_r <= edit_nxt;
  end

endmodule

FILE: rtl/alarm_clock_with_set_modes.sv
// ----------------------------------------------------------------------------
// alarm_clock_with_set_modes
// 24-hour alarm clock with time-set and alarm-set modes.
// ----------------------------------------------------------------------------
// Takes one word per clock, either a millisecond tick (op 0) or a key scan
// sample (op 1), and returns one result word for each, in order. A word is
// captured in an input register, the clock state is updated in one pass of
// logic, and the result lands in an output register that drives out_valid,
// with a sustained rate of one word per cycle as long as out_ready is high.
// A stalled result holds while one more word waits in the input register.
// The user must set prescaler limits over the APB port only while idle (word
// 0 ticks per second, word 1 ticks per blink toggle); no logic enforces it.
module alarm_clock_with_set_modes (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_op,
  input  logic [4:0]                in_key_code,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_mode,
  output logic [4:0]                out_shown_hours,
  output logic [5:0]                out_shown_minutes,
  output logic [5:0]                out_shown_seconds,
  output logic [1:0]                out_field_select,
  output logic                      out_blink_phase,
  output logic                      out_alarm_armed,
  output logic                      out_alarm_ringing,
  output logic [7:0]                out_led_bits,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [alc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import alc_pkg::*;

  logic       in_vld_r;
  logic       op_r;
  logic [4:0] key_r;
  logic       out_vld_r;
  res_t       res_r;
  res_t       res;
  cfg_t       cfg;
  logic       step;

  // input register moves on when the output register is free or draining
  assign step     = in_vld_r & (~out_vld_r | out_ready);
  assign in_ready = ~in_vld_r | step;

  alc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  alc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .op       (op_r),
    .key_code (key_r),
    .cfg      (cfg),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) in_vld_r <= in_valid;
      if (step)           out_vld_r <= 1'b1;
      else if (out_ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= in_op;
      key_r <= in_key_code;
    end
    if (step) res_r <= res;
  end

  assign out_valid         = out_vld_r;
  assign out_mode          = res_r.mode;
  assign out_shown_hours   = res_r.shown.h;
  assign out_shown_minutes = res_r.shown.m;
  assign out_shown_seconds = res_r.shown.s;
  assign out_field_select  = res_r.field_sel;
  assign out_blink_phase   = res_r.blink;
  assign out_alarm_armed   = res_r.armed;
  assign out_alarm_ringing = res_r.ringing;
  assign out_led_bits      = res_r.leds;

endmodule

FILE: rtl/alc_checker.sv
// ----------------------------------------------------------------------------
// alc_checker
// Port-level checks for the alarm clock, bound to the top level.
// ----------------------------------------------------------------------------
module alc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_mode,
  input logic [4:0] out_shown_hours,
  input logic [5:0] out_shown_minutes,
  input logic [5:0] out_shown_seconds,
  input logic       out_blink_phase,
  input logic       out_alarm_armed,
  input logic       out_alarm_ringing,
  input logic [7:0] out_led_bits
);
  import alc_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_led_bits)
      && $stable(out_mode) && $stable(out_shown_seconds))
    else $error("result word changed while stalled");

  // LEDs only light while armed, ringing and in the on phase
  a_led_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_led_bits != 8'd0 |->
      out_alarm_armed && out_alarm_ringing && out_blink_phase)
    else $error("LEDs lit without a ringing alarm");

  // lit nibble follows the hour; only the running time is shown in show mode
  a_led_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode == MODE_SHOW && out_led_bits != 8'd0 |->
      (out_led_bits == LED_PM && out_shown_hours >= HOUR_PM)
      || (out_led_bits == LED_AM && out_shown_hours < HOUR_PM))
    else $error("wrong LED half for hour");

  // running time always in range
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode == MODE_SHOW |->
      out_shown_hours <= HOUR_MAX && out_shown_minutes <= MS_MAX
      && out_shown_seconds <= MS_MAX)
    else $error("shown time out of range");

endmodule

bind alarm_clock_with_set_modes alc_checker u_alc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_mode          (out_mode),
  .out_shown_hours   (out_shown_hours),
  .out_shown_minutes (out_shown_minutes),
  .out_shown_seconds (out_shown_seconds),
  .out_blink_phase   (out_blink_phase),
  .out_alarm_armed   (out_alarm_armed),
  .out_alarm_ringing (out_alarm_ringing),
  .out_led_bits      (out_led_bits)
);
